@@ hw/rtl/patt_pkg.sv @@
// Shared types and constants for the periodic alarm timer table.
// Beat payload structs, operation codes and the memory command group.
// No dependencies.
package patt_pkg;

    localparam int SLOT_W   = 3;
    localparam int PERIOD_W = 15;
    localparam int MASK_W   = 8;
    localparam int OP_W     = 3;

    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD        = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd2;
    localparam logic [OP_W-1:0] OP_ACTIVATE   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEACTIVATE = 3'd4;
    localparam logic [OP_W-1:0] OP_SERVICE    = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period;
        logic                in_isr;
    } patt_in_t;

    typedef struct packed {
        logic                ok;
        logic [SLOT_W-1:0]   slot_out;
        logic [MASK_W-1:0]   fire_mask;
        logic [MASK_W-1:0]   pending_mask;
        logic                run_callback;
    } patt_out_t;

    typedef struct packed {
        logic rd_en;
        logic per_we;
        logic cnt_we;
    } patt_mem_cmd_t;

endpackage

@@ hw/rtl/patt_mem.sv @@
// Period and tick count stores of the alarm table, one row per slot.
// One write port per store, shared registered read port. Uses patt_pkg.
module patt_mem
    import patt_pkg::*;
#(
    parameter int NUM_SLOTS = 8,
    parameter int IDX_W     = 3
) (
    input  logic                aclk,
    input  patt_mem_cmd_t       cmd,
    input  logic [IDX_W-1:0]    rd_addr,
    input  logic [IDX_W-1:0]    wr_addr,
    input  logic [PERIOD_W-1:0] per_wdata,
    input  logic [PERIOD_W-1:0] cnt_wdata,
    output logic [PERIOD_W-1:0] per_rdata,
    output logic [PERIOD_W-1:0] cnt_rdata
);

    logic [PERIOD_W-1:0] per_mem [NUM_SLOTS];
    logic [PERIOD_W-1:0] cnt_mem [NUM_SLOTS];
    logic [PERIOD_W-1:0] per_rdata_reg;
    logic [PERIOD_W-1:0] cnt_rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.per_we) begin
            per_mem[wr_addr] <= per_wdata;
        end
        if (cmd.rd_en) begin
            per_rdata_reg <= per_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cnt_we) begin
            cnt_mem[wr_addr] <= cnt_wdata;
        end
        if (cmd.rd_en) begin
            cnt_rdata_reg <= cnt_mem[rd_addr];
        end
    end

    assign per_rdata = per_rdata_reg;
    assign cnt_rdata = cnt_rdata_reg;

endmodule

@@ hw/rtl/periodic_alarm_timer_table.sv @@
// Periodic alarm timer table: slot flags in flops, period and count in patt_mem.
// Add, remove, activate, deactivate and service: result valid in the cycle after the beat.
// Tick: walks every slot through the count store, one slot a cycle, as a read-modify-write
// of the count store; the result is loaded once the walk is done and the output is free.
// One item at a time. Synchronous active-low reset frees all slots; stores need no clearing.
module periodic_alarm_timer_table
    import patt_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  patt_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output patt_out_t m_payload
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int EXT_W = IDX_W + 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_TFIN
    } state_t;

    state_t                 state_reg, state_next;
    logic [NUM_SLOTS-1:0]   used_reg, used_next;
    logic [NUM_SLOTS-1:0]   active_reg, active_next;
    logic [NUM_SLOTS-1:0]   imm_reg, imm_next;
    logic [NUM_SLOTS-1:0]   pending_reg, pending_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]       proc_idx_reg, proc_idx_next;
    logic [MASK_W-1:0]      fire_reg, fire_next;
    logic [SLOT_W-1:0]      tick_slot_reg, tick_slot_next;
    logic                   m_valid_reg, m_valid_next;
    patt_out_t              out_reg, out_next;

    patt_mem_cmd_t          mem_cmd;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic [PERIOD_W-1:0]    per_wdata;
    logic [PERIOD_W-1:0]    cnt_wdata;
    logic [PERIOD_W-1:0]    per_rdata;
    logic [PERIOD_W-1:0]    cnt_rdata;

    logic [EXT_W-1:0]       slot_ext;
    logic [IDX_W-1:0]       slot_idx;
    logic                   in_use;
    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic [PERIOD_W-1:0]    per_eff;
    logic [PERIOD_W-1:0]    cnt_inc;
    logic                   expire;
    logic [NUM_SLOTS+MASK_W-1:0] fire_onehot;
    logic [NUM_SLOTS+MASK_W-1:0] pend_ext;
    logic                   load_out;

    patt_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_mem (
        .aclk      (aclk),
        .cmd       (mem_cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .per_wdata (per_wdata),
        .cnt_wdata (cnt_wdata),
        .per_rdata (per_rdata),
        .cnt_rdata (cnt_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    assign slot_ext = EXT_W'(s_payload.slot);
    assign slot_idx = slot_ext[IDX_W-1:0];
    assign in_use   = (slot_ext < EXT_W'(NUM_SLOTS)) && used_reg[slot_idx];

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign per_eff     = (per_rdata == '0) ? PERIOD_W'(1) : per_rdata;
    assign cnt_inc     = cnt_rdata + PERIOD_W'(1);
    assign expire      = cnt_inc >= per_eff;
    assign fire_onehot = (NUM_SLOTS+MASK_W)'(1) << proc_idx_reg;

    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        active_next    = active_reg;
        imm_next       = imm_reg;
        pending_next   = pending_reg;
        rd_idx_next    = rd_idx_reg;
        proc_vld_next  = proc_vld_reg;
        proc_idx_next  = proc_idx_reg;
        fire_next      = fire_reg;
        tick_slot_next = tick_slot_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_next       = out_reg;
        load_out       = 1'b0;
        mem_cmd        = '0;
        rd_addr        = '0;
        wr_addr        = '0;
        per_wdata      = '0;
        cnt_wdata      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    out_next.ok           = 1'b0;
                    out_next.slot_out     = s_payload.slot;
                    out_next.fire_mask    = '0;
                    out_next.run_callback = 1'b0;
                    priority if (s_payload.operation == OP_TICK) begin
                        state_next     = ST_TICK;
                        rd_idx_next    = '0;
                        proc_vld_next  = 1'b0;
                        fire_next      = '0;
                        tick_slot_next = s_payload.slot;
                    end else if (s_payload.operation == OP_ADD) begin
                        if (free_found) begin
                            used_next[free_idx]    = 1'b1;
                            active_next[free_idx]  = 1'b0;
                            imm_next[free_idx]     = s_payload.in_isr;
                            pending_next[free_idx] = 1'b0;
                            mem_cmd.per_we         = 1'b1;
                            mem_cmd.cnt_we         = 1'b1;
                            wr_addr                = free_idx;
                            per_wdata              = s_payload.period;
                            out_next.ok            = 1'b1;
                            out_next.slot_out      = SLOT_W'(free_idx);
                        end
                        load_out = 1'b1;
                    end else if (s_payload.operation == OP_REMOVE) begin
                        if (in_use) begin
                            used_next[slot_idx]    = 1'b0;
                            active_next[slot_idx]  = 1'b0;
                            pending_next[slot_idx] = 1'b0;
                            out_next.ok            = 1'b1;
                        end
                        load_out = 1'b1;
                    end else if (s_payload.operation == OP_ACTIVATE) begin
                        if (in_use) begin
                            active_next[slot_idx] = 1'b1;
                            mem_cmd.cnt_we        = 1'b1;
                            wr_addr               = slot_idx;
                            out_next.ok           = 1'b1;
                        end
                        load_out = 1'b1;
                    end else if (s_payload.operation == OP_DEACTIVATE) begin
                        if (in_use) begin
                            active_next[slot_idx] = 1'b0;
                            out_next.ok           = 1'b1;
                        end
                        load_out = 1'b1;
                    end else if (s_payload.operation == OP_SERVICE) begin
                        if (in_use) begin
                            out_next.ok = 1'b1;
                            if (pending_reg[slot_idx]) begin
                                pending_next[slot_idx] = 1'b0;
                                out_next.run_callback  = 1'b1;
                            end
                        end
                        load_out = 1'b1;
                    end else begin
                        load_out = 1'b1;
                    end
                end
            end
            ST_TICK: begin
                // update the slot read last cycle
                if (proc_vld_reg && used_reg[proc_idx_reg] && active_reg[proc_idx_reg]) begin
                    mem_cmd.cnt_we = 1'b1;
                    wr_addr        = proc_idx_reg;
                    cnt_wdata      = expire ? '0 : cnt_inc;
                    if (expire) begin
                        if (imm_reg[proc_idx_reg]) begin
                            fire_next = fire_reg | fire_onehot[MASK_W-1:0];
                        end else begin
                            pending_next[proc_idx_reg] = 1'b1;
                        end
                    end
                end
                // issue the next slot read
                if (rd_idx_reg < CNT_W'(NUM_SLOTS)) begin
                    mem_cmd.rd_en = 1'b1;
                    rd_addr       = rd_idx_reg[IDX_W-1:0];
                    proc_vld_next = 1'b1;
                    proc_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end else begin
                    proc_vld_next = 1'b0;
                    if (!proc_vld_reg) begin
                        state_next = ST_TFIN;
                    end
                end
            end
            ST_TFIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.ok           = 1'b1;
                    out_next.slot_out     = tick_slot_reg;
                    out_next.fire_mask    = fire_reg;
                    out_next.run_callback = 1'b0;
                    load_out              = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        pend_ext = {{MASK_W{1'b0}}, pending_next};
        if (load_out) begin
            out_next.pending_mask = pend_ext[MASK_W-1:0];
            m_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            active_reg   <= '0;
            imm_reg      <= '0;
            pending_reg  <= '0;
            rd_idx_reg   <= '0;
            proc_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            active_reg   <= active_next;
            imm_reg      <= imm_next;
            pending_reg  <= pending_next;
            rd_idx_reg   <= rd_idx_next;
            proc_vld_reg <= proc_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        proc_idx_reg  <= proc_idx_next;
        fire_reg      <= fire_next;
        tick_slot_reg <= tick_slot_next;
        out_reg       <= out_next;
    end

    a_pending_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg & ~used_reg) == '0)
        else $error("pending flag on a free slot");

    a_active_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg & ~used_reg) == '0)
        else $error("active flag on a free slot");

    a_proc_in_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_vld_reg |-> state_reg == ST_TICK)
        else $error("slot update outside tick walk");

    a_tick_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.operation == OP_TICK) |=>
            (state_reg == ST_TICK && !proc_vld_reg))
        else $error("tick beat did not start the walk");

    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready)
        else $error("input taken during tick walk");

endmodule
